/* sv/frct_pkg.sv */
// ----------------------------------------------------------------------------
// frct_pkg
// Shared types and constants for the fullness-ranked capacity table.
// ----------------------------------------------------------------------------
package frct_pkg;

   localparam int TABLE_DEPTH_DEF = 16;
   localparam int KEY_W           = 16;
   localparam int VAL_W           = 32;
   localparam int RANK_W          = 4;
   localparam int COUNT_OUT_W     = 5;

   typedef enum logic [1:0] {
      KIND_REGISTER   = 2'd0,
      KIND_UNREGISTER = 2'd1,
      KIND_SET_LIVE   = 2'd2,
      KIND_QUERY      = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_NOKEY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] cap;
      logic [VAL_W-1:0] live;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // outcome of one pairwise fullness compare
   typedef struct packed {
      logic j_fuller;   // entry j strictly fuller than entry i
      logic tie;        // equal fullness
   } cmp_res_type;

endpackage

/* sv/frct_if.sv */
// ----------------------------------------------------------------------------
// frct request / response channels
// Valid/ready channels carrying one request word and one response word.
// ----------------------------------------------------------------------------
interface frct_req_if;
   import frct_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          kind;
   logic [KEY_W-1:0]    entry_key;
   logic [VAL_W-1:0]    capacity;
   logic [VAL_W-1:0]    live_value;
   logic [RANK_W-1:0]   rank;

   modport source (output valid, kind, entry_key, capacity, live_value, rank, input ready);
   modport sink   (input valid, kind, entry_key, capacity, live_value, rank, output ready);
endinterface

interface frct_rsp_if;
   import frct_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [KEY_W-1:0]       found_key;
   logic [VAL_W-1:0]       found_capacity;
   logic [VAL_W-1:0]       found_live;
   logic [COUNT_OUT_W-1:0] entry_count;
   logic [1:0]             status;

   modport source (output valid, found_key, found_capacity, found_live, entry_count, status,
                   input ready);
   modport sink   (input valid, found_key, found_capacity, found_live, entry_count, status,
                   output ready);
endinterface

/* sv/fullness_ranked_capacity_table_core.sv */
// ----------------------------------------------------------------------------
// fullness_ranked_capacity_table_core
// Table of capacity entries with append, swap-remove, live update and
// query by fullness rank.
// ----------------------------------------------------------------------------
//  channel  dir  word
//  req_ch   in   kind, entry_key, capacity, live_value, rank
//  rsp_ch   out  found_key, found_capacity, found_live, entry_count, status
//
//  Every word passes through the accept and the finish state.
//  Register: written on accept. Unregister / set live: key scan, reading and
//  checking one slot at a time, then unregister reads the last entry and
//  writes it into a non-tail hole. Query: for each candidate slot i, read and
//  load it, then a pass over the other slots (read, multiply, compare) through
//  one shared cross-multiply compare, skipping its own slot, then an end check.
//  One word at a time; the response register frees the request side as soon
//  as the word is loaded. Reset (synchronous) empties the table; slot
//  contents are not cleared since only slots below the count are read.
// ----------------------------------------------------------------------------
module fullness_ranked_capacity_table_core #(
   parameter int TABLE_DEPTH = frct_pkg::TABLE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   frct_req_if.sink   req_ch,
   frct_rsp_if.source rsp_ch
);
   import frct_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_MOVE_RD, S_MOVE_WR,
      S_Q_RDI, S_Q_LDI, S_Q_RDJ, S_Q_MUL, S_Q_CMP, S_Q_END, S_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    i_ff, i_in, j_ff, j_in, r_ff, r_in;
   logic [AW-1:0]    at_ff, at_in;
   kind_type         kind_ff, kind_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] live_ff, live_in;
   logic [RANK_W-1:0] rank_ff, rank_in;
   entry_type        ent_i_ff, ent_i_in;
   status_type       status_ff, status_in;
   logic             hit_ff, hit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   entry_type        out_ent_ff, out_ent_in;
   logic [COUNT_OUT_W-1:0] out_count_ff, out_count_in;
   status_type       out_status_ff, out_status_in;

   logic             mem_we;
   logic [AW-1:0]    mem_waddr, mem_raddr;
   entry_type        mem_wdata, mem_rdata;
   logic             cmp_load;
   cmp_res_type      cmp_res;

   frct_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   frct_cmp u_cmp (
      .clock  (clock),
      .load   (cmp_load),
      .cap_i  (ent_i_ff.cap),
      .live_i (ent_i_ff.live),
      .cap_j  (mem_rdata.cap),
      .live_j (mem_rdata.live),
      .res    (cmp_res)
   );

   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      r_in          = r_ff;
      at_in         = at_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      live_in       = live_ff;
      rank_in       = rank_ff;
      ent_i_in      = ent_i_ff;
      status_in     = status_ff;
      hit_in        = hit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      out_ent_in    = out_ent_ff;
      out_count_in  = out_count_ff;
      out_status_in = out_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = count_ff[AW-1:0];
      mem_wdata     = '{key: req_ch.entry_key, cap: req_ch.capacity, live: req_ch.live_value};
      mem_raddr     = i_ff[AW-1:0];
      cmp_load      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               kind_in   = kind_type'(req_ch.kind);
               key_in    = req_ch.entry_key;
               live_in   = req_ch.live_value;
               rank_in   = req_ch.rank;
               status_in = ST_OK;
               hit_in    = 1'b0;
               i_in      = '0;
               state_in  = S_FINISH;
               unique case (kind_type'(req_ch.kind))
                  KIND_REGISTER: begin
                     if (count_ff == CW'(TABLE_DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_we   = 1'b1;     // append at the tail
                        count_in = count_ff + CW'(1);
                     end
                  end
                  KIND_UNREGISTER, KIND_SET_LIVE: begin
                     if (count_ff == '0) status_in = ST_NOKEY;
                     else state_in = S_SCAN_RD;
                  end
                  default: begin
                     if (32'(req_ch.rank) >= 32'(count_ff)) status_in = ST_RANGE;
                     else state_in = S_Q_RDI;
                  end
               endcase
            end
         end

         S_SCAN_RD: state_in = S_SCAN_CHK;

         S_SCAN_CHK: begin
            if (mem_rdata.key == key_ff) begin
               at_in    = i_ff[AW-1:0];
               state_in = S_FINISH;
               if (kind_ff == KIND_SET_LIVE) begin
                  mem_we    = 1'b1;
                  mem_waddr = i_ff[AW-1:0];
                  mem_wdata = '{key: mem_rdata.key, cap: mem_rdata.cap, live: live_ff};
               end else begin
                  count_in = count_ff - CW'(1);
                  // hole is not the tail: move the tail entry into it
                  if (i_ff != count_ff - CW'(1)) state_in = S_MOVE_RD;
               end
            end else if (i_ff + CW'(1) == count_ff) begin
               status_in = ST_NOKEY;
               state_in  = S_FINISH;
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = S_SCAN_RD;
            end
         end

         S_MOVE_RD: begin
            mem_raddr = count_ff[AW-1:0];
            state_in  = S_MOVE_WR;
         end

         S_MOVE_WR: begin
            mem_we    = 1'b1;
            mem_waddr = at_ff;
            mem_wdata = mem_rdata;
            state_in  = S_FINISH;
         end

         S_Q_RDI: state_in = S_Q_LDI;

         S_Q_LDI: begin
            ent_i_in = mem_rdata;
            j_in     = '0;
            r_in     = '0;
            state_in = S_Q_RDJ;
         end

         S_Q_RDJ: begin
            mem_raddr = j_ff[AW-1:0];
            if (j_ff == count_ff) begin
               state_in = S_Q_END;
            end else if (j_ff == i_ff) begin
               j_in = j_ff + CW'(1);
            end else begin
               state_in = S_Q_MUL;
            end
         end

         S_Q_MUL: begin
            cmp_load = 1'b1;
            state_in = S_Q_CMP;
         end

         S_Q_CMP: begin
            // j ranks ahead if fuller, or equally full from a lower slot
            if (cmp_res.j_fuller || (cmp_res.tie && (j_ff < i_ff))) r_in = r_ff + CW'(1);
            j_in     = j_ff + CW'(1);
            state_in = S_Q_RDJ;
         end

         S_Q_END: begin
            if (32'(r_ff) == 32'(rank_ff)) begin
               hit_in   = 1'b1;
               state_in = S_FINISH;
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = S_Q_RDI;
            end
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               out_ent_in    = hit_ff ? ent_i_ff : '0;
               out_count_in  = COUNT_OUT_W'(count_ff);
               out_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff          <= i_in;
      j_ff          <= j_in;
      r_ff          <= r_in;
      at_ff         <= at_in;
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      live_ff       <= live_in;
      rank_ff       <= rank_in;
      ent_i_ff      <= ent_i_in;
      status_ff     <= status_in;
      hit_ff        <= hit_in;
      out_ent_ff    <= out_ent_in;
      out_count_ff  <= out_count_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.found_key      = out_ent_ff.key;
   assign rsp_ch.found_capacity = out_ent_ff.cap;
   assign rsp_ch.found_live     = out_ent_ff.live;
   assign rsp_ch.entry_count    = out_count_ff;
   assign rsp_ch.status         = out_status_ff;
endmodule

/* sv/frct_ram.sv */
// ----------------------------------------------------------------------------
// frct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* sv/frct_cmp.sv */
// ----------------------------------------------------------------------------
// frct_cmp
// Exact fullness compare by registered cross products.
// ----------------------------------------------------------------------------
module frct_cmp (
   input  logic                    clock,
   input  logic                    load,
   input  logic [frct_pkg::VAL_W-1:0] cap_i,
   input  logic [frct_pkg::VAL_W-1:0] live_i,
   input  logic [frct_pkg::VAL_W-1:0] cap_j,
   input  logic [frct_pkg::VAL_W-1:0] live_j,
   output frct_pkg::cmp_res_type   res
);
   import frct_pkg::*;

   logic [VAL_W-1:0]   num_i, den_i, num_j, den_j;
   logic [2*VAL_W-1:0] prod_ji_ff, prod_ij_ff;

   // zero capacity reads as 0/1
   always_comb begin
      num_i = (cap_i != '0) ? live_i : '0;
      den_i = (cap_i != '0) ? cap_i  : VAL_W'(1);
      num_j = (cap_j != '0) ? live_j : '0;
      den_j = (cap_j != '0) ? cap_j  : VAL_W'(1);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ji_ff <= {{VAL_W{1'b0}}, num_j} * {{VAL_W{1'b0}}, den_i};
         prod_ij_ff <= {{VAL_W{1'b0}}, num_i} * {{VAL_W{1'b0}}, den_j};
      end
   end

   assign res.j_fuller = prod_ji_ff > prod_ij_ff;
   assign res.tie      = prod_ji_ff == prod_ij_ff;
endmodule

/* sv/frct_chk.sv */
// ----------------------------------------------------------------------------
// frct_chk
// Port-level checks for the fullness-ranked capacity table.
// ----------------------------------------------------------------------------
module frct_chk #(
   parameter int TABLE_DEPTH = frct_pkg::TABLE_DEPTH_DEF
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [frct_pkg::KEY_W-1:0]         found_key,
   input logic [frct_pkg::VAL_W-1:0]         found_capacity,
   input logic [frct_pkg::VAL_W-1:0]         found_live,
   input logic [frct_pkg::COUNT_OUT_W-1:0]   entry_count,
   input logic [1:0]                         status
);
   import frct_pkg::*;

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(entry_count) && $stable(status)
                                   && $stable(found_key))
      else $error("response word changed under stall");

   // refusals and misses carry no entry
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status != ST_OK) |-> found_key == '0 && found_capacity == '0
                                         && found_live == '0)
      else $error("non-ok response carries entry data");

   // a full refusal reports a full table
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == ST_FULL) |-> entry_count == COUNT_OUT_W'(TABLE_DEPTH))
      else $error("full refusal with table not full");

   // one word at a time: busy right after an accept
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // nothing pending right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("block not idle after reset");
endmodule

bind fullness_ranked_capacity_table_core frct_chk #(.TABLE_DEPTH(TABLE_DEPTH)) u_frct_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .found_key      (rsp_ch.found_key),
   .found_capacity (rsp_ch.found_capacity),
   .found_live     (rsp_ch.found_live),
   .entry_count    (rsp_ch.entry_count),
   .status         (rsp_ch.status)
);

/* tb/frct_tb_if.sv */
// ----------------------------------------------------------------------------
// frct testbench channel note
// The request and response interfaces come with the RTL (frct_if.sv); this
// file only carries the word structs the testbench uses to queue requests and responses.
// ----------------------------------------------------------------------------
package frct_tb_pkg;
   import frct_pkg::*;

   typedef struct {
      kind_type         kind;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] cap;
      logic [VAL_W-1:0] live;
      logic [RANK_W-1:0] rank;
   } req_word_type;

   typedef struct {
      logic [KEY_W-1:0]       key;
      logic [VAL_W-1:0]       cap;
      logic [VAL_W-1:0]       live;
      logic [COUNT_OUT_W-1:0] count;
      status_type             status;
   } rsp_word_type;
endpackage

/* tb/fullness_ranked_capacity_table_core_tb.sv */
// ----------------------------------------------------------------------------
// fullness_ranked_capacity_table_core_tb
// Drives register, unregister, set-live and rank queries into the table,
// predicts every response word with a shadow table and checks them in order.
// ----------------------------------------------------------------------------
import frct_pkg::*;
import frct_tb_pkg::*;

class table_scoreboard;
   logic [KEY_W-1:0] keys[TABLE_DEPTH_DEF];
   logic [VAL_W-1:0] caps[TABLE_DEPTH_DEF];
   logic [VAL_W-1:0] lives[TABLE_DEPTH_DEF];
   int held;
   rsp_word_type pending[$];
   int errors;
   int checked;

   function new();
      held = 0;
      errors = 0;
      checked = 0;
   endfunction

   // slot a strictly fuller than slot b, exact cross-multiply
   function bit fuller(int a, int b);
      logic [63:0] na, da, nb, db;
      na = (caps[a] != 0) ? 64'(lives[a]) : 64'd0;
      da = (caps[a] != 0) ? 64'(caps[a]) : 64'd1;
      nb = (caps[b] != 0) ? 64'(lives[b]) : 64'd0;
      db = (caps[b] != 0) ? 64'(caps[b]) : 64'd1;
      return na * db > nb * da;
   endfunction

   function int position_of(int i);
      int r;
      r = 0;
      for (int j = 0; j < held; j++) begin
         if (j == i) continue;
         if (fuller(j, i)) r++;
         else if (j < i && !fuller(i, j)) r++;
      end
      return r;
   endfunction

   function int lookup(logic [KEY_W-1:0] k);
      for (int i = 0; i < held; i++) if (keys[i] == k) return i;
      return -1;
   endfunction

   function void note_request(req_word_type w);
      rsp_word_type e;
      int at;
      e = '{key: '0, cap: '0, live: '0, count: '0, status: ST_OK};
      case (w.kind)
         KIND_REGISTER: begin
            if (held >= TABLE_DEPTH_DEF) e.status = ST_FULL;
            else begin
               keys[held] = w.key;
               caps[held] = w.cap;
               lives[held] = w.live;
               held++;
            end
         end
         KIND_UNREGISTER: begin
            at = lookup(w.key);
            if (at < 0) e.status = ST_NOKEY;
            else begin
               held--;
               keys[at] = keys[held];
               caps[at] = caps[held];
               lives[at] = lives[held];
            end
         end
         KIND_SET_LIVE: begin
            at = lookup(w.key);
            if (at < 0) e.status = ST_NOKEY;
            else lives[at] = w.live;
         end
         default: begin
            if (w.rank >= held) e.status = ST_RANGE;
            else begin
               for (int i = 0; i < held; i++) begin
                  if (position_of(i) == w.rank) begin
                     e.key = keys[i];
                     e.cap = caps[i];
                     e.live = lives[i];
                     break;
                  end
               end
            end
         end
      endcase
      e.count = COUNT_OUT_W'(held);
      pending.push_back(e);
   endfunction

   function void check_response(rsp_word_type a);
      rsp_word_type e;
      checked++;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected response word, status %0d", a.status);
         return;
      end
      e = pending.pop_front();
      if (a.key !== e.key || a.cap !== e.cap || a.live !== e.live ||
          a.count !== e.count || a.status !== e.status) begin
         errors++;
         if (errors <= 10)
            $display({"mismatch: exp key %h cap %h live %h cnt %0d st %0d,",
                      " got key %h cap %h live %h cnt %0d st %0d"},
                     e.key, e.cap, e.live, e.count, e.status,
                     a.key, a.cap, a.live, a.count, a.status);
      end
   endfunction
endclass

module fullness_ranked_capacity_table_core_tb;
   logic clock = 1'b0;
   logic reset = 1'b1;

   frct_req_if req_ch();
   frct_rsp_if rsp_ch();

   fullness_ranked_capacity_table_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always #5 clock = ~clock;

   table_scoreboard board = new();
   bit  idle_off;        // last part of the run: no bubbles, no stalls
   bit  long_hold;       // receiver held off for a long stretch
   int  cycles;
   int  sent;
   int  queries;
   int  refusals;
   logic [KEY_W-1:0] used_keys[$];

   initial begin
      req_ch.valid = 1'b0;
      req_ch.kind = '0;
      req_ch.entry_key = '0;
      req_ch.capacity = '0;
      req_ch.live_value = '0;
      req_ch.rank = '0;
      rsp_ch.ready = 1'b0;
   end

   // one request word; valid stays high across back-to-back words
   task automatic send_word(req_word_type w);
      req_ch.valid <= 1'b1;
      req_ch.kind <= w.kind;
      req_ch.entry_key <= w.key;
      req_ch.capacity <= w.cap;
      req_ch.live_value <= w.live;
      req_ch.rank <= w.rank;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(w);
      sent++;
      if (w.kind == KIND_QUERY) queries++;
      if (w.kind == KIND_REGISTER) used_keys.push_back(w.key);
      // bubble after the word now and then
      if (!idle_off && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return VAL_W'($urandom_range(0, 20));
         3: return 32'h8000_0000 | $urandom;
         default: return $urandom;
      endcase
   endfunction

   // key from those seen, so unregister and set-live mostly hit
   function automatic logic [KEY_W-1:0] pick_key();
      if (used_keys.size() != 0 && $urandom_range(0, 4) != 0)
         return used_keys[$urandom_range(0, used_keys.size() - 1)];
      return KEY_W'($urandom);
   endfunction

   function automatic req_word_type make_word(kind_type k);
      req_word_type w;
      w.kind = k;
      w.key = pick_key();
      w.cap = pick_value();
      w.live = pick_value();
      w.rank = RANK_W'($urandom);
      if (k == KIND_REGISTER && $urandom_range(0, 3) == 0) w.key = KEY_W'($urandom);
      return w;
   endfunction

   function automatic req_word_type random_word();
      int p;
      p = $urandom_range(0, 99);
      // keep the table busy: bias toward registers while it is shallow
      if (p < ((board.held < 8) ? 45 : 25)) return make_word(KIND_REGISTER);
      if (p < 55) return make_word(KIND_UNREGISTER);
      if (p < 70) return make_word(KIND_SET_LIVE);
      return make_word(KIND_QUERY);
   endfunction

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   // sender
   initial begin
      req_word_type w;
      sent = 0;
      queries = 0;
      idle_off = 1'b0;
      long_hold = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty-table cases
      send_word('{KIND_QUERY, 16'h0000, 32'h0, 32'h0, 4'h0});
      send_word('{KIND_UNREGISTER, 16'hFFFF, 32'h0, 32'h0, 4'h0});
      send_word('{KIND_SET_LIVE, 16'h1234, 32'h0, 32'hFFFF_FFFF, 4'h0});
      // field extremes, zero capacity, duplicate keys, equal fullness
      send_word('{KIND_REGISTER, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF});
      send_word('{KIND_REGISTER, 16'h0000, 32'h0, 32'hFFFF_FFFF, 4'h0});
      send_word('{KIND_REGISTER, 16'h0001, 32'd4, 32'd2, 4'h0});
      send_word('{KIND_REGISTER, 16'h0001, 32'd8, 32'd4, 4'h0});
      send_word('{KIND_REGISTER, 16'hAAAA, 32'd1, 32'hFFFF_FFFF, 4'h0});
      for (int r = 0; r < 6; r++) send_word('{KIND_QUERY, 16'h0, 32'h0, 32'h0, RANK_W'(r)});
      send_word('{KIND_SET_LIVE, 16'h0001, 32'h0, 32'd8, 4'h0});
      send_word('{KIND_UNREGISTER, 16'h0001, 32'h0, 32'h0, 4'h0});
      send_word('{KIND_QUERY, 16'h0, 32'h0, 32'h0, 4'h0});
      // fill to the top, then one refused register
      while (board.held < TABLE_DEPTH_DEF) send_word(make_word(KIND_REGISTER));
      send_word('{KIND_REGISTER, 16'h5555, 32'h1, 32'h1, 4'h0});
      send_word('{KIND_QUERY, 16'h0, 32'h0, 32'h0, 4'hF});

      // pause until every expected word has come
      wait_drained();

      // long receiver hold-off while the sender keeps offering
      long_hold = 1'b1;
      for (int n = 0; n < 12; n++) send_word(random_word());
      long_hold = 1'b0;

      for (int n = 0; n < 1000; n++) begin
         if (n == 850) idle_off = 1'b1;
         send_word(random_word());
      end
      wait_drained();
      repeat (3 * TABLE_DEPTH_DEF * TABLE_DEPTH_DEF + 100) @(posedge clock);

      $display("%0d request words (%0d rank queries), %0d response words checked",
               sent, queries, board.checked);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // receiver: random stall bursts, one long hold while long_hold is set
   initial begin
      int hold;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_ch.ready <= 1'b0;
            hold = 400;
            while (hold > 0) begin
               @(posedge clock);
               hold--;
            end
            rsp_ch.ready <= 1'b1;
            wait (!long_hold);
         end else if (!idle_off && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_word_type a;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         a.key = rsp_ch.found_key;
         a.cap = rsp_ch.found_capacity;
         a.live = rsp_ch.found_live;
         a.count = rsp_ch.entry_count;
         a.status = status_type'(rsp_ch.status);
         board.check_response(a);
      end
   end

   // watchdog: ~1100 words at the worst-case query time plus stalls, taken 3x
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3_000_000) begin
         $display("simulation failed");
         $finish;
      end
   end
   initial cycles = 0;
endmodule
